[sv/jspaf_pkg.sv]
`timescale 1ns / 1ps

package jspaf_pkg;

    // commands carried by each input item
    typedef enum logic [3:0] {
        CMD_UP       = 4'd0,
        CMD_DOWN     = 4'd1,
        CMD_LEFT     = 4'd2,
        CMD_RIGHT    = 4'd3,
        CMD_FIRE     = 4'd4,
        CMD_REL_X    = 4'd5,
        CMD_REL_Y    = 4'd6,
        CMD_REL_XY   = 4'd7,
        CMD_REL_FIRE = 4'd8,
        CMD_TICK     = 4'd9
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] CFG_AUTOFIRE = 2'd0;
    localparam logic [1:0] CFG_MAGAZINE = 2'd1;
    localparam logic [1:0] CFG_HALF_PER = 2'd2;

    localparam int CFG_DATA_BITS = 17;

    // axis encoding
    localparam logic [1:0] AXIS_CENTER = 2'd0;
    localparam logic [1:0] AXIS_POS    = 2'd1;
    localparam logic [1:0] AXIS_NEG    = 2'd3;

    // reset values of the configuration registers
    localparam logic [16:0] MAGAZINE_RESET = 17'h1FFFD;
    localparam logic [7:0]  HALF_PER_RESET = 8'd10;

    // one input item as held in the input register
    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] frame_number;
        logic [7:0]  mouse_bits;
    } item_t;

endpackage

[sv/jspaf_in_stage.sv]
`timescale 1ns / 1ps

module jspaf_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [3:0]        cmd,
    input  logic [31:0]       frame_number,
    input  logic [7:0]        mouse_bits,
    input  logic              out_ready,
    output logic              in_stall,
    output logic              item_valid,
    output jspaf_pkg::item_t  item
);

    logic             valid_reg;
    logic             valid_next;
    jspaf_pkg::item_t item_reg;
    logic             accept;

    // held item moves on whenever the output register can take it
    assign in_stall = valid_reg && !out_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd          <= cmd;
            item_reg.frame_number <= frame_number;
            item_reg.mouse_bits   <= mouse_bits;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/jspaf_engine.sv]
`timescale 1ns / 1ps

module jspaf_engine #(
    parameter int SHOT_COUNT_BITS = 16,
    parameter int FRAME_BITS      = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [jspaf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                  advance,
    input  jspaf_pkg::item_t                      item,
    output logic [7:0]                            result
);

    localparam logic [32:0] SHOT_MAX_W = (33'd1 << SHOT_COUNT_BITS) - 33'd1;

    logic                       autofire_reg,   autofire_next;
    logic [16:0]                magazine_reg,   magazine_next;
    logic [7:0]                 half_per_reg,   half_per_next;
    logic [1:0]                 vert_reg,       vert_next;
    logic [1:0]                 horiz_reg,      horiz_next;
    logic                       fire_reg,       fire_next;
    logic [SHOT_COUNT_BITS-1:0] shots_reg,      shots_next;
    logic                       unlimited_reg,  unlimited_next;
    logic [FRAME_BITS-1:0]      toggle_reg,     toggle_next;

    logic [63:0]                frame_wide;
    logic [FRAME_BITS-1:0]      frame_cur;
    logic [FRAME_BITS-1:0]      frame_sched;
    logic                       firing;
    logic [7:0]                 port_raw;

    // shot count loaded from a magazine value, saturated to the counter; zero for an unlimited magazine
    function automatic logic [SHOT_COUNT_BITS-1:0] load_count(input logic [16:0] mag);
        logic [32:0] v;
        v = {17'd0, mag[15:0]};
        if (mag[16])
        begin
            load_count = '0;
        end
        else if (v > SHOT_MAX_W)
        begin
            load_count = SHOT_MAX_W[SHOT_COUNT_BITS-1:0];
        end
        else
        begin
            load_count = v[SHOT_COUNT_BITS-1:0];
        end
    endfunction

    assign frame_wide  = {32'd0, item.frame_number};
    assign frame_cur   = frame_wide[FRAME_BITS-1:0];
    assign frame_sched = frame_cur + FRAME_BITS'(half_per_reg);
    assign firing      = unlimited_reg || (shots_reg != '0);

    always_comb
    begin
        autofire_next  = autofire_reg;
        magazine_next  = magazine_reg;
        half_per_next  = half_per_reg;
        vert_next      = vert_reg;
        horiz_next     = horiz_reg;
        fire_next      = fire_reg;
        shots_next     = shots_reg;
        unlimited_next = unlimited_reg;
        toggle_next    = toggle_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                jspaf_pkg::CFG_AUTOFIRE: autofire_next = cfg_data[0];
                jspaf_pkg::CFG_MAGAZINE:
                begin
                    magazine_next = cfg_data;
                    // reload while firing
                    if (firing)
                    begin
                        unlimited_next = cfg_data[16];
                        shots_next     = load_count(cfg_data);
                    end
                end
                jspaf_pkg::CFG_HALF_PER: half_per_next = cfg_data[7:0];
                default: ;
            endcase
        end
        else if (advance)
        begin
            unique case (jspaf_pkg::cmd_t'(item.cmd))
                jspaf_pkg::CMD_UP:     vert_next  = jspaf_pkg::AXIS_NEG;
                jspaf_pkg::CMD_DOWN:   vert_next  = jspaf_pkg::AXIS_POS;
                jspaf_pkg::CMD_LEFT:   horiz_next = jspaf_pkg::AXIS_NEG;
                jspaf_pkg::CMD_RIGHT:  horiz_next = jspaf_pkg::AXIS_POS;
                jspaf_pkg::CMD_FIRE:
                begin
                    if (!autofire_reg)
                    begin
                        fire_next = 1'b1;
                    end
                    else if (firing)
                    begin
                        shots_next     = '0;
                        unlimited_next = 1'b0;
                        fire_next      = 1'b0;
                    end
                    else
                    begin
                        unlimited_next = magazine_reg[16];
                        shots_next     = load_count(magazine_reg);
                        fire_next      = 1'b1;
                        toggle_next    = frame_sched;
                    end
                end
                jspaf_pkg::CMD_REL_X:  horiz_next = jspaf_pkg::AXIS_CENTER;
                jspaf_pkg::CMD_REL_Y:  vert_next  = jspaf_pkg::AXIS_CENTER;
                jspaf_pkg::CMD_REL_XY:
                begin
                    horiz_next = jspaf_pkg::AXIS_CENTER;
                    vert_next  = jspaf_pkg::AXIS_CENTER;
                end
                jspaf_pkg::CMD_REL_FIRE:
                begin
                    if (!autofire_reg)
                    begin
                        fire_next = 1'b0;
                    end
                end
                jspaf_pkg::CMD_TICK:
                begin
                    if (autofire_reg && (half_per_reg != 8'd0) &&
                        (frame_cur == toggle_reg) && firing)
                    begin
                        fire_next   = !fire_reg;
                        toggle_next = frame_sched;
                        // a release uses up one shot
                        if (fire_reg && !unlimited_reg)
                        begin
                            shots_next = shots_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autofire_reg  <= 1'b0;
            magazine_reg  <= jspaf_pkg::MAGAZINE_RESET;
            half_per_reg  <= jspaf_pkg::HALF_PER_RESET;
            vert_reg      <= jspaf_pkg::AXIS_CENTER;
            horiz_reg     <= jspaf_pkg::AXIS_CENTER;
            fire_reg      <= 1'b0;
            shots_reg     <= '0;
            unlimited_reg <= 1'b0;
            toggle_reg    <= '0;
        end
        else
        begin
            autofire_reg  <= autofire_next;
            magazine_reg  <= magazine_next;
            half_per_reg  <= half_per_next;
            vert_reg      <= vert_next;
            horiz_reg     <= horiz_next;
            fire_reg      <= fire_next;
            shots_reg     <= shots_next;
            unlimited_reg <= unlimited_next;
            toggle_reg    <= toggle_next;
        end
    end

    // port byte from the updated state
    always_comb
    begin
        port_raw = 8'hFF;
        if (vert_next == jspaf_pkg::AXIS_NEG)
        begin
            port_raw[0] = 1'b0;
        end
        if (vert_next == jspaf_pkg::AXIS_POS)
        begin
            port_raw[1] = 1'b0;
        end
        if (horiz_next == jspaf_pkg::AXIS_NEG)
        begin
            port_raw[2] = 1'b0;
        end
        if (horiz_next == jspaf_pkg::AXIS_POS)
        begin
            port_raw[3] = 1'b0;
        end
        if (fire_next)
        begin
            port_raw[4] = 1'b0;
        end
    end

    assign result = port_raw & item.mouse_bits;

    a_unlimited_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        unlimited_reg |-> (shots_reg == '0))
        else $error("unlimited supply with a nonzero shot count");

    a_tick_off_holds_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we && (item.cmd == jspaf_pkg::CMD_TICK) && !autofire_reg)
        |=> $stable(fire_reg))
        else $error("tick changed the button with autofire off");

    a_axis_codes: assert property (@(posedge clk) disable iff (!rst_n)
        (vert_reg != 2'd2) && (horiz_reg != 2'd2))
        else $error("axis holds an unused code");

endmodule

[sv/jspaf_out_stage.sv]
`timescale 1ns / 1ps

module jspaf_out_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] result,
    input  logic       out_stall,
    output logic       out_ready,
    output logic       out_valid,
    output logic [7:0] port_bits
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] bits_reg;

    assign out_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bits_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign port_bits = bits_reg;

endmodule

[sv/joystick_port_with_autofire_core.sv]
`timescale 1ns / 1ps

// digital joystick port with autofire
// input channel: in_valid / in_stall carry cmd, frame_number and mouse_bits;
//   each transfer is one joystick event or one frame tick
// output channel: out_valid / out_stall carry port_bits, one transfer per
//   input transfer, in order; the byte is active low and ANDed with mouse_bits
// config port: cfg_we writes cfg_data into register cfg_index (0 autofire
//   enable, 1 shots per magazine, 2 half period in frames); write only while
//   no item is in flight
// path: the input transfer fills the input register, then the state update
//   writes the result register and raises out_valid
// throughput: one item per cycle while out_stall is low; the state update is one pass of compares
//   and one frame add between the input register and the result register
// stall: with out_stall high the result register holds, the input register
//   fills, and in_stall rises only when both are occupied
// reset: rst_n clears both stages, centers the axes, releases fire, empties
//   the shot counter and loads the config defaults (autofire off, magazine
//   unlimited, half period 10)
module joystick_port_with_autofire_core #(
    parameter int SHOT_COUNT_BITS = 16,
    parameter int FRAME_BITS      = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          cmd,
    input  logic [31:0]                         frame_number,
    input  logic [7:0]                          mouse_bits,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          port_bits,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [jspaf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic             item_valid;
    jspaf_pkg::item_t item;
    logic             out_ready;
    logic             advance;
    logic [7:0]       result;

    // held item moves into the result register this cycle
    assign advance = item_valid && out_ready;

    jspaf_in_stage u_in (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .cmd          (cmd),
        .frame_number (frame_number),
        .mouse_bits   (mouse_bits),
        .out_ready    (out_ready),
        .in_stall     (in_stall),
        .item_valid   (item_valid),
        .item         (item)
    );

    jspaf_engine #(
        .SHOT_COUNT_BITS (SHOT_COUNT_BITS),
        .FRAME_BITS      (FRAME_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    jspaf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .result    (result),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .port_bits (port_bits)
    );

    // back pressure only comes from a blocked result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back pressure");

    // a held item always reaches the result register when it is free
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !(out_valid && out_stall)) |=> out_valid)
        else $error("held item was not moved to the output");

    // bits 5-7 of a fresh result follow the mouse bits
    a_upper_bits: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (port_bits[7:5] == $past(item.mouse_bits[7:5])))
        else $error("upper port bits differ from mouse bits");

endmodule
